/* design/ctlc_pkg.sv */
// ---------------------------------------------------------------------------
// ctlc_pkg: shared types and constants for the line-crossing tracker
// Holds defaults, register map, and controller/datapath interface types.
// ---------------------------------------------------------------------------
package ctlc_pkg;

	localparam int MAX_TRACKS_DEF     = 32;
	localparam int MAX_DETECTIONS_DEF = 32;
	localparam int COORD_BITS_DEF     = 12;

	// index and count fields wide enough for the largest table (256 entries)
	localparam int IDX_W = 8;
	localparam int CNT_W = 9;

	localparam logic [11:0] FRAME_WIDTH_RST = 12'd640;
	localparam logic [7:0]  MAX_MISSING_RST = 8'd10;
	localparam logic [24:0] MAX_DIST_RST    = 25'd2500;

	// register map, word index
	localparam logic [1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [1:0] REG_MAX_MISSING = 2'd1;
	localparam logic [1:0] REG_MAX_DIST    = 2'd2;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SCAN,
		OP_APPLY,
		OP_AGE,
		OP_NEW
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] trk_idx;
		logic [IDX_W-1:0] det_idx;
		logic             finish;
	} cmd_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] best_trk;
		logic [IDX_W-1:0] best_det;
		logic [CNT_W-1:0] trk_total;
		logic [CNT_W-1:0] det_total;
		logic             out_full;
	} stat_t;

	typedef struct packed {
		logic [11:0] frame_width;
		logic [7:0]  max_missing;
		logic [24:0] max_dist_sq;
	} cfg_t;

endpackage

/* design/centroid_tracker_line_counter.sv */
// Frame handling: a frame_end word holds the input until the frame's pair scans,
//   match updates, aging, new-track insertion and result hand-off are done;
//   the pair scan reads one track and one detection per cycle.
// Throughput: one word per cycle between frame ends; one frame at a time.
// Reset: asynchronous, active low; clears tables to empty and loads register defaults.
// ---------------------------------------------------------------------------
// centroid_tracker_line_counter: top level
// Greedy nearest-neighbor centroid tracker that counts midline crossings.
// ---------------------------------------------------------------------------
module centroid_tracker_line_counter #(
	parameter int MAX_TRACKS     = ctlc_pkg::MAX_TRACKS_DEF,
	parameter int MAX_DETECTIONS = ctlc_pkg::MAX_DETECTIONS_DEF,
	parameter int COORD_BITS     = ctlc_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] box_x,
	input  logic [COORD_BITS-1:0] box_y,
	input  logic [COORD_BITS-1:0] box_width,
	input  logic [COORD_BITS-1:0] box_height,
	input  logic                  box_present,
	input  logic                  frame_end,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [6:0]     net_crossings,
	output logic [5:0]            track_count,
	output logic                  overflow
);

	ctlc_pkg::cfg_t  cfg;
	ctlc_pkg::cmd_t  cmd;
	ctlc_pkg::stat_t stat;
	logic            in_take;

	assign in_take = in_valid && !in_stall;

	ctlc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ctlc_ctrl #(
		.MAX_TRACKS     (MAX_TRACKS),
		.MAX_DETECTIONS (MAX_DETECTIONS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.frame_end (frame_end),
		.stat      (stat),
		.cmd       (cmd),
		.in_stall  (in_stall)
	);

	ctlc_dpath #(
		.MAX_TRACKS     (MAX_TRACKS),
		.MAX_DETECTIONS (MAX_DETECTIONS),
		.COORD_BITS     (COORD_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.stat          (stat),
		.in_take       (in_take),
		.box_x         (box_x),
		.box_y         (box_y),
		.box_width     (box_width),
		.box_height    (box_height),
		.box_present   (box_present),
		.frame_end     (frame_end),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.net_crossings (net_crossings),
		.track_count   (track_count),
		.overflow      (overflow)
	);

endmodule

/* design/ctlc_regs.sv */
// ---------------------------------------------------------------------------
// ctlc_regs: configuration register file
// APB-style write/read of frame width, miss limit and distance limit.
// ---------------------------------------------------------------------------
module ctlc_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output ctlc_pkg::cfg_t     cfg
);

	ctlc_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width <= ctlc_pkg::FRAME_WIDTH_RST;
			cfg_q.max_missing <= ctlc_pkg::MAX_MISSING_RST;
			cfg_q.max_dist_sq <= ctlc_pkg::MAX_DIST_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				ctlc_pkg::REG_FRAME_WIDTH: cfg_q.frame_width <= pwdata[11:0];
				ctlc_pkg::REG_MAX_MISSING: cfg_q.max_missing <= pwdata[7:0];
				ctlc_pkg::REG_MAX_DIST:    cfg_q.max_dist_sq <= pwdata[24:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[3:2])
			ctlc_pkg::REG_FRAME_WIDTH: prdata = {20'd0, cfg_q.frame_width};
			ctlc_pkg::REG_MAX_MISSING: prdata = {24'd0, cfg_q.max_missing};
			ctlc_pkg::REG_MAX_DIST:    prdata = {7'd0, cfg_q.max_dist_sq};
			default:                   prdata = 32'd0;
		endcase
	end

endmodule

/* design/ctlc_ctrl.sv */
// ---------------------------------------------------------------------------
// ctlc_ctrl: frame sequencer
// Walks pair scans, match updates, track aging and new-track insertion.
// ---------------------------------------------------------------------------
module ctlc_ctrl #(
	parameter int MAX_TRACKS     = ctlc_pkg::MAX_TRACKS_DEF,
	parameter int MAX_DETECTIONS = ctlc_pkg::MAX_DETECTIONS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            frame_end,
	input  ctlc_pkg::stat_t stat,
	output ctlc_pkg::cmd_t  cmd,
	output logic            in_stall
);

	localparam int TI = $clog2(MAX_TRACKS);
	localparam int DI = $clog2(MAX_DETECTIONS);
	localparam int CW = ctlc_pkg::CNT_W;

	typedef enum logic [3:0] {
		IDLE, SCAN, DRAIN, PICK, APPLY_RD, APPLY_WT,
		AGE, AGE_WT, NEWD, NEWD_WT, FINISH
	} state_t;

	state_t          state_q;
	logic [TI-1:0]   ti_q;
	logic [DI-1:0]   dj_q;
	logic [1:0]      drain_q;
	logic            ti_last;
	logic            dj_last;
	logic            trk_empty;
	logic            det_empty;

	assign ti_last   = (CW'(ti_q) + CW'(1)) == stat.trk_total;
	assign dj_last   = (CW'(dj_q) + CW'(1)) == stat.det_total;
	assign trk_empty = stat.trk_total == '0;
	assign det_empty = stat.det_total == '0;
	assign in_stall  = state_q != IDLE;

	// issue commands
	always_comb begin
		cmd         = '0;
		cmd.op      = ctlc_pkg::OP_NONE;
		cmd.trk_idx = ctlc_pkg::IDX_W'(ti_q);
		cmd.det_idx = ctlc_pkg::IDX_W'(dj_q);
		unique case (state_q)
			SCAN: if (!trk_empty && !det_empty) cmd.op = ctlc_pkg::OP_SCAN;
			APPLY_RD: begin
				cmd.op      = ctlc_pkg::OP_APPLY;
				cmd.trk_idx = stat.best_trk;
				cmd.det_idx = stat.best_det;
			end
			AGE:    if (!trk_empty) cmd.op = ctlc_pkg::OP_AGE;
			NEWD:   if (!det_empty) cmd.op = ctlc_pkg::OP_NEW;
			FINISH: cmd.finish = !stat.out_full;
			default: ;
		endcase
	end

	// sequence the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ti_q    <= '0;
			dj_q    <= '0;
			drain_q <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid && frame_end) begin
						state_q <= SCAN;
						ti_q    <= '0;
						dj_q    <= '0;
					end
				end
				SCAN: begin
					if (trk_empty || det_empty) begin
						state_q <= AGE;
						ti_q    <= '0;
					end else if (dj_last) begin
						dj_q <= '0;
						if (ti_last) begin
							state_q <= DRAIN;
							drain_q <= '0;
						end else begin
							ti_q <= ti_q + TI'(1);
						end
					end else begin
						dj_q <= dj_q + DI'(1);
					end
				end
				DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd2) state_q <= PICK;
				end
				PICK: begin
					if (stat.found) begin
						state_q <= APPLY_RD;
					end else begin
						state_q <= AGE;
						ti_q    <= '0;
					end
				end
				APPLY_RD: state_q <= APPLY_WT;
				APPLY_WT: begin
					state_q <= SCAN;
					ti_q    <= '0;
					dj_q    <= '0;
				end
				AGE: begin
					if (trk_empty) begin
						state_q <= NEWD;
						dj_q    <= '0;
					end else if (ti_last) begin
						state_q <= AGE_WT;
					end else begin
						ti_q <= ti_q + TI'(1);
					end
				end
				AGE_WT: begin
					state_q <= NEWD;
					dj_q    <= '0;
				end
				NEWD: begin
					if (det_empty) state_q <= FINISH;
					else if (dj_last) state_q <= NEWD_WT;
					else dj_q <= dj_q + DI'(1);
				end
				NEWD_WT: state_q <= FINISH;
				FINISH:  if (!stat.out_full) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

/* design/ctlc_dpath.sv */
// ---------------------------------------------------------------------------
// ctlc_dpath: tracker datapath
// Detection and track stores, distance pipeline, best-pair pick, result word.
// ---------------------------------------------------------------------------
module ctlc_dpath #(
	parameter int MAX_TRACKS     = ctlc_pkg::MAX_TRACKS_DEF,
	parameter int MAX_DETECTIONS = ctlc_pkg::MAX_DETECTIONS_DEF,
	parameter int COORD_BITS     = ctlc_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctlc_pkg::cfg_t        cfg,
	input  ctlc_pkg::cmd_t        cmd,
	output ctlc_pkg::stat_t       stat,
	input  logic                  in_take,
	input  logic [COORD_BITS-1:0] box_x,
	input  logic [COORD_BITS-1:0] box_y,
	input  logic [COORD_BITS-1:0] box_width,
	input  logic [COORD_BITS-1:0] box_height,
	input  logic                  box_present,
	input  logic                  frame_end,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic signed [6:0]     net_crossings,
	output logic [5:0]            track_count,
	output logic                  overflow
);

	localparam int TI = $clog2(MAX_TRACKS);
	localparam int DI = $clog2(MAX_DETECTIONS);
	localparam int TC = $clog2(MAX_TRACKS + 1);
	localparam int DC = $clog2(MAX_DETECTIONS + 1);
	localparam int CB = COORD_BITS;
	localparam int TW = 2 * CB + 8;
	localparam int SW = (CB + 1 > 13) ? CB + 1 : 13;
	localparam int MW = (CB > 12) ? CB : 12;
	localparam int DW = 2 * CB + 1;
	localparam int BW = (DW > 25) ? DW : 25;
	localparam logic [CB-1:0] COORD_MAX = '1;

	// stores
	logic [TW-1:0]   trk_mem [2**(TI+1)];
	logic [2*CB-1:0] det_mem [MAX_DETECTIONS];

	logic [TW-1:0]   trk_rd_s1;
	logic [2*CB-1:0] det_rd_s1;
	logic            trk_we;
	logic [TW-1:0]   trk_wd;
	logic            det_we;
	logic [2*CB-1:0] det_wd;

	// control state
	logic              bank_q;
	logic [TC-1:0]     trk_total_q;
	logic [DC-1:0]     det_total_q;
	logic [TC-1:0]     n_q;
	logic              det_ovf_q;
	logic              frm_ovf_q;
	logic signed [6:0] net_q;
	logic [MAX_TRACKS-1:0]     tused_q;
	logic [MAX_DETECTIONS-1:0] dused_q;
	logic [BW-1:0]     best_q;
	logic              found_q;
	logic [TI-1:0]     bi_q;
	logic [DI-1:0]     bj_q;
	logic              out_valid_q;

	// pipeline
	ctlc_pkg::op_t   op_s1;
	logic [TI-1:0]   ti_s1;
	logic [DI-1:0]   dj_s1;
	logic            v_s2;
	logic [TI-1:0]   ti_s2;
	logic [DI-1:0]   dj_s2;
	logic [CB-1:0]   dx_s2;
	logic [CB-1:0]   dy_s2;
	logic            v_s3;
	logic [TI-1:0]   ti_s3;
	logic [DI-1:0]   dj_s3;
	logic [2*CB-1:0] sqx_s3;
	logic [2*CB-1:0] sqy_s3;

	// centroid of the incoming box
	logic [SW-1:0] cx_sum;
	logic [SW-1:0] cy_sum;
	logic [CB-1:0] cx;
	logic [CB-1:0] cy;

	assign cx_sum = SW'(box_x) + SW'(box_width >> 1);
	assign cy_sum = SW'(box_y) + SW'(box_height >> 1);
	assign cx     = (cx_sum > SW'(COORD_MAX)) ? COORD_MAX : CB'(cx_sum);
	assign cy     = (cy_sum > SW'(COORD_MAX)) ? COORD_MAX : CB'(cy_sum);
	assign det_we = in_take && box_present && (det_total_q < DC'(MAX_DETECTIONS));
	assign det_wd = {cx, cy};

	// fields of the words read last cycle
	logic [CB-1:0] t_x, t_y, d_x, d_y;
	logic [7:0]    t_m;
	logic [8:0]    miss_inc;
	logic          n_room;
	logic          age_keep;
	logic          new_live;
	logic [MW-1:0] ox_e, nx_e, mid_e;
	logic          cross_r, cross_l;

	assign t_x      = trk_rd_s1[TW-1 -: CB];
	assign t_y      = trk_rd_s1[CB+7 -: CB];
	assign t_m      = trk_rd_s1[7:0];
	assign d_x      = det_rd_s1[2*CB-1 -: CB];
	assign d_y      = det_rd_s1[CB-1:0];
	assign miss_inc = {1'b0, t_m} + 9'd1;
	assign n_room   = n_q < TC'(MAX_TRACKS);
	assign age_keep = !tused_q[ti_s1] && n_room && (miss_inc <= {1'b0, cfg.max_missing});
	assign new_live = !dused_q[dj_s1];
	assign ox_e     = MW'(t_x);
	assign nx_e     = MW'(d_x);
	assign mid_e    = MW'(cfg.frame_width >> 1);
	assign cross_r  = (ox_e <= mid_e) && (nx_e > mid_e);
	assign cross_l  = (ox_e >= mid_e) && (nx_e < mid_e);

	// build the next track list entry
	always_comb begin
		trk_we = 1'b0;
		trk_wd = {d_x, d_y, 8'd0};
		unique case (op_s1)
			ctlc_pkg::OP_APPLY: trk_we = 1'b1;
			ctlc_pkg::OP_AGE: begin
				trk_we = age_keep;
				trk_wd = {t_x, t_y, miss_inc[7:0]};
			end
			ctlc_pkg::OP_NEW: trk_we = new_live && n_room;
			default: ;
		endcase
	end

	// track store, two banks: read current, write next
	always_ff @(posedge clk) begin
		if (trk_we) trk_mem[{!bank_q, n_q[TI-1:0]}] <= trk_wd;
		trk_rd_s1 <= trk_mem[{bank_q, cmd.trk_idx[TI-1:0]}];
	end

	// detection store
	always_ff @(posedge clk) begin
		if (det_we) det_mem[det_total_q[DI-1:0]] <= det_wd;
		det_rd_s1 <= det_mem[cmd.det_idx[DI-1:0]];
	end

	// distance pipeline payload
	logic [DW-1:0] dsum;

	assign dsum = DW'(sqx_s3) + DW'(sqy_s3);

	always_ff @(posedge clk) begin
		ti_s2  <= ti_s1;
		dj_s2  <= dj_s1;
		dx_s2  <= (t_x > d_x) ? t_x - d_x : d_x - t_x;
		dy_s2  <= (t_y > d_y) ? t_y - d_y : d_y - t_y;
		ti_s3  <= ti_s2;
		dj_s3  <= dj_s2;
		sqx_s3 <= dx_s2 * dx_s2;
		sqy_s3 <= dy_s2 * dy_s2;
	end

	// control registers and best-pair tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1       <= ctlc_pkg::OP_NONE;
			ti_s1       <= '0;
			dj_s1       <= '0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			bank_q      <= 1'b0;
			trk_total_q <= '0;
			det_total_q <= '0;
			n_q         <= '0;
			det_ovf_q   <= 1'b0;
			frm_ovf_q   <= 1'b0;
			net_q       <= '0;
			tused_q     <= '0;
			dused_q     <= '0;
			best_q      <= '0;
			found_q     <= 1'b0;
			bi_q        <= '0;
			bj_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			op_s1 <= cmd.op;
			ti_s1 <= cmd.trk_idx[TI-1:0];
			dj_s1 <= cmd.det_idx[DI-1:0];
			v_s2  <= (op_s1 == ctlc_pkg::OP_SCAN) && !tused_q[ti_s1] && !dused_q[dj_s1];
			v_s3  <= v_s2;

			// keep the closest pair below the limit, first one on ties
			if (v_s3 && (BW'(dsum) < best_q)) begin
				best_q  <= BW'(dsum);
				found_q <= 1'b1;
				bi_q    <= ti_s3;
				bj_q    <= dj_s3;
			end

			// buffer a detection or flag the drop
			if (in_take && box_present) begin
				if (det_we) det_total_q <= det_total_q + DC'(1);
				else det_ovf_q <= 1'b1;
			end
			if (in_take && frame_end) begin
				best_q  <= BW'(cfg.max_dist_sq);
				found_q <= 1'b0;
				tused_q <= '0;
				dused_q <= '0;
			end

			// commit a match, start next round
			if (op_s1 == ctlc_pkg::OP_APPLY) begin
				tused_q[ti_s1] <= 1'b1;
				dused_q[dj_s1] <= 1'b1;
				best_q         <= BW'(cfg.max_dist_sq);
				found_q        <= 1'b0;
				if (cross_r) net_q <= net_q + 7'sd1;
				else if (cross_l) net_q <= net_q - 7'sd1;
			end
			if (trk_we) n_q <= n_q + TC'(1);
			if ((op_s1 == ctlc_pkg::OP_NEW) && new_live && !n_room) frm_ovf_q <= 1'b1;

			// raise the result word at frame close, drop it once taken
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			// close the frame
			if (cmd.finish) begin
				bank_q      <= !bank_q;
				trk_total_q <= n_q;
				n_q         <= '0;
				det_total_q <= '0;
				det_ovf_q   <= 1'b0;
				frm_ovf_q   <= 1'b0;
				net_q       <= '0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			net_crossings <= net_q;
			track_count   <= 6'(n_q);
			overflow      <= det_ovf_q || frm_ovf_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign stat.found     = found_q;
	assign stat.best_trk  = ctlc_pkg::IDX_W'(bi_q);
	assign stat.best_det  = ctlc_pkg::IDX_W'(bj_q);
	assign stat.trk_total = ctlc_pkg::CNT_W'(trk_total_q);
	assign stat.det_total = ctlc_pkg::CNT_W'(det_total_q);
	assign stat.out_full  = out_valid_q && out_stall;

endmodule

/* design/ctlc_checker.sv */
// ---------------------------------------------------------------------------
// ctlc_checker: port-level checks for the tracker
// Frame handoff and result word ordering as seen on the ports.
// ---------------------------------------------------------------------------
module ctlc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              frame_end,
	input logic              out_valid,
	input logic              out_stall,
	input logic signed [6:0] net_crossings,
	input logic [5:0]        track_count,
	input logic              overflow
);

	// a frame end closes the input until the frame is processed
	a_frame_locks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && frame_end |=> in_stall)
		else $error("input open right after frame end");

	// a result word appears only while input is held off
	a_result_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result word without frame processing");

	// a result word does not rise straight after a frame end is taken
	a_result_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && !in_stall && frame_end))
		else $error("result word too early after frame end");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(net_crossings)
			&& $stable(track_count) && $stable(overflow))
		else $error("stalled result word changed");

endmodule

bind centroid_tracker_line_counter ctlc_checker u_ctlc_checker (.*);

/* tb/centroid_tracker_line_counter_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// centroid_tracker_line_counter_test: self-checking bench for the tracker
// Feeds frames of detection boxes, predicts greedy matching, crossing count,
// track total and overflow per frame, and compares each result word.
// ---------------------------------------------------------------------------
module centroid_tracker_line_counter_test;

	localparam int NTRK = 32;
	localparam int NDET = 32;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct {
		logic [11:0] x, y, w, h;
		logic        present, fend;
	} box_word_t;

	typedef struct {
		logic signed [6:0] net;
		logic [5:0]        count;
		logic              ovf;
	} frame_result_t;

	logic clk = 1'b0, arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	logic in_valid = 1'b0, in_stall;
	logic [11:0] box_x = '0, box_y = '0, box_width = '0, box_height = '0;
	logic box_present = 1'b0, frame_end = 1'b0;
	logic out_valid, out_stall = 1'b0;
	logic signed [6:0] net_crossings;
	logic [5:0] track_count;
	logic overflow;

	centroid_tracker_line_counter DUT (.*);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic [11:0] cfg_width = ctlc_pkg::FRAME_WIDTH_RST;
	logic [7:0]  cfg_missing = ctlc_pkg::MAX_MISSING_RST;
	logic [24:0] cfg_dist = ctlc_pkg::MAX_DIST_RST;
	logic [11:0] trk_x[NTRK], trk_y[NTRK];
	int          trk_miss[NTRK];
	int          trk_n = 0;
	logic [11:0] det_x[NDET], det_y[NDET];
	int          det_n = 0;
	bit          det_ovf = 0;

	box_word_t     pending_words[$];
	frame_result_t expected_frames[$];
	int errors = 0, frames_seen = 0, words_sent = 0, cycles = 0;

	// append a word to the stimulus queue
	function automatic void add_word(box_word_t b);
		pending_words.insert(pending_words.size(), b);
	endfunction

	function automatic logic [11:0] centroid(logic [11:0] p, logic [11:0] s);
		int c;
		c = p + (s >> 1);
		return (c > 4095) ? 12'd4095 : c[11:0];
	endfunction

	// apply one accepted word to the tracker model
	task automatic track_word(box_word_t wd);
		logic [11:0] nx[NTRK], ny[NTRK];
		int nm[NTRK];
		bit tused[NTRK], dused[NDET];
		int n, net, bi, bj, mid, m;
		longint best, d, dx, dy;
		bit ovf;
		frame_result_t r;
		n = 0; net = 0;
		if (wd.present) begin
			if (det_n < NDET) begin
				det_x[det_n] = centroid(wd.x, wd.w);
				det_y[det_n] = centroid(wd.y, wd.h);
				det_n++;
			end else det_ovf = 1;
		end
		if (!wd.fend) return;
		ovf = det_ovf;
		mid = cfg_width >> 1;
		foreach (tused[i]) tused[i] = 0;
		foreach (dused[i]) dused[i] = 0;
		forever begin
			best = cfg_dist; bi = -1; bj = -1;
			for (int i = 0; i < trk_n; i++) begin
				if (tused[i]) continue;
				for (int j = 0; j < det_n; j++) begin
					if (dused[j]) continue;
					dx = longint'(trk_x[i]) - longint'(det_x[j]);
					dy = longint'(trk_y[i]) - longint'(det_y[j]);
					d = dx * dx + dy * dy;
					if (d < best) begin
						best = d; bi = i; bj = j;
					end
				end
			end
			if (bi < 0) break;
			if (trk_x[bi] <= mid && det_x[bj] > mid) net++;
			else if (trk_x[bi] >= mid && det_x[bj] < mid) net--;
			tused[bi] = 1; dused[bj] = 1;
			nx[n] = det_x[bj]; ny[n] = det_y[bj]; nm[n] = 0; n++;
		end
		// age unmatched tracks
		for (int i = 0; i < trk_n; i++) begin
			if (tused[i]) continue;
			m = trk_miss[i] + 1;
			if (m <= cfg_missing && n < NTRK) begin
				nx[n] = trk_x[i]; ny[n] = trk_y[i]; nm[n] = m; n++;
			end
		end
		// spawn new tracks
		for (int j = 0; j < det_n; j++) begin
			if (dused[j]) continue;
			if (n < NTRK) begin
				nx[n] = det_x[j]; ny[n] = det_y[j]; nm[n] = 0; n++;
			end else ovf = 1;
		end
		for (int i = 0; i < n; i++) begin
			trk_x[i] = nx[i]; trk_y[i] = ny[i]; trk_miss[i] = nm[i];
		end
		trk_n = n; det_n = 0; det_ovf = 0;
		r.net = 7'(net); r.count = 6'(n); r.ovf = ovf;
		expected_frames.insert(expected_frames.size(), r);
	endtask

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// driver: hold the word while stalled, advance after acceptance
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				track_word(pending_words.pop_front());
				words_sent++;
			end
			if (!(in_valid && in_stall)) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					box_x <= pending_words[0].x;
					box_y <= pending_words[0].y;
					box_width <= pending_words[0].w;
					box_height <= pending_words[0].h;
					box_present <= pending_words[0].present;
					frame_end <= pending_words[0].fend;
					in_valid <= 1'b1;
					in_gap <= gap_len();
				end else in_valid <= 1'b0;
			end
		end
	end

	// monitor and receiver stall
	always @(posedge clk) begin
		frame_result_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				frames_seen++;
				if (expected_frames.size() == 0) begin
					$error("unexpected result word");
					errors++;
				end else begin
					e = expected_frames.pop_front();
					if (net_crossings !== e.net) begin
						$error("net_crossings exp %0d got %0d", e.net, net_crossings);
						errors++;
					end
					if (track_count !== e.count) begin
						$error("track_count exp %0d got %0d", e.count, track_count);
						errors++;
					end
					if (overflow !== e.ovf) begin
						$error("overflow exp %0d got %0d", e.ovf, overflow);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < 25) ? (gap_len() != 0) : 1'b0;
		end
	end

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			ctlc_pkg::REG_FRAME_WIDTH: cfg_width = val[11:0];
			ctlc_pkg::REG_MAX_MISSING: cfg_missing = val[7:0];
			default:                   cfg_dist = val[24:0];
		endcase
	endtask

	// wait until the block has drained every word and result
	task automatic drain();
		while (pending_words.size() > 0 || in_valid || expected_frames.size() > 0)
			@(posedge clk);
		repeat (40000) @(posedge clk);
	endtask

	function automatic box_word_t mk(int x, int y, int w, int h, int p, int f);
		box_word_t b;
		b.x = 12'(x); b.y = 12'(y); b.w = 12'(w); b.h = 12'(h);
		b.present = 1'(p); b.fend = 1'(f);
		return b;
	endfunction

	// objects that drift across the frame, plus noise boxes
	int obj_x[8], obj_y[8];
	task automatic random_frames(int count, int step);
		int nb;
		for (int f = 0; f < count; f++) begin
			nb = $urandom_range(0, 7);
			for (int k = 0; k < nb; k++) begin
				if ($urandom_range(0, 9) < 8) begin
					obj_x[k] = (obj_x[k] + $urandom_range(0, 2 * step) - step) & 12'hfff;
					obj_y[k] = (obj_y[k] + $urandom_range(0, step) - step / 2) & 12'hfff;
					add_word(mk(obj_x[k], obj_y[k],
						$urandom_range(0, 20), $urandom_range(0, 20), 1, 0));
				end else
					add_word(mk($urandom, $urandom, $urandom, $urandom,
						$urandom_range(0, 1), 0));
			end
			add_word(mk($urandom, $urandom, $urandom, $urandom,
				$urandom_range(0, 1), 1));
		end
	endtask

	initial begin
		foreach (obj_x[i]) begin
			obj_x[i] = $urandom_range(0, 639); obj_y[i] = $urandom_range(0, 479);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// directed: extremes, saturation, empty frame, crossing both ways
		add_word(mk(0, 0, 0, 0, 0, 1));
		add_word(mk(4095, 4095, 4095, 4095, 1, 1));
		add_word(mk(310, 100, 0, 0, 1, 1));
		add_word(mk(330, 100, 0, 0, 1, 1));
		add_word(mk(310, 100, 0, 0, 1, 1));
		add_word(mk(320, 100, 0, 0, 1, 1));
		add_word(mk(0, 0, 0, 0, 0, 0));
		add_word(mk(0, 0, 0, 0, 0, 1));
		drain();
		// full table: 34 boxes in one frame
		for (int k = 0; k < 34; k++) add_word(mk(k * 100, 7, 2, 2, 1, k == 33));
		add_word(mk(5, 3000, 0, 0, 1, 1));
		drain();
		reg_write(ctlc_pkg::REG_FRAME_WIDTH, 32'd0);
		reg_write(ctlc_pkg::REG_MAX_MISSING, 32'd0);
		reg_write(ctlc_pkg::REG_MAX_DIST, 32'd0);
		random_frames(8, 30);
		drain();
		reg_write(ctlc_pkg::REG_FRAME_WIDTH, 32'd4095);
		reg_write(ctlc_pkg::REG_MAX_MISSING, 32'd255);
		reg_write(ctlc_pkg::REG_MAX_DIST, 32'h1ffffff);
		random_frames(12, 200);
		drain();
		reg_write(ctlc_pkg::REG_FRAME_WIDTH, 32'd640);
		reg_write(ctlc_pkg::REG_MAX_MISSING, 32'd3);
		reg_write(ctlc_pkg::REG_MAX_DIST, 32'd900);
		random_frames(40, 25);
		drain();
		reg_write(ctlc_pkg::REG_FRAME_WIDTH, 32'd1);
		reg_write(ctlc_pkg::REG_MAX_MISSING, 32'd1);
		reg_write(ctlc_pkg::REG_MAX_DIST, 32'd5000);
		random_frames(22, 40);
		drain();
		$display("Sent %0d box words, checked %0d frame results over five register settings.",
			words_sent, frames_seen);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

/* filelist.f */
design/ctlc_pkg.sv
design/ctlc_regs.sv
design/ctlc_ctrl.sv
design/ctlc_dpath.sv
design/centroid_tracker_line_counter.sv
design/ctlc_checker.sv
tb/centroid_tracker_line_counter_test.sv
